// File: design/murmur3_32_byte_stream_hash_macros.svh
// Assertion macros shared by the murmur3 byte stream hash RTL.
`ifndef MURMUR3_32_BYTE_STREAM_HASH_MACROS_SVH
`define MURMUR3_32_BYTE_STREAM_HASH_MACROS_SVH

`ifndef SYNTHESIS
`define MM3_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MM3_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/mm3bsh_pkg.sv
// Package: constants, datapath commands and status for the murmur3 byte stream hash.
`timescale 1ns / 1ps
package mm3bsh_pkg;

    localparam logic [31:0] C1   = 32'hcc9e2d51;
    localparam logic [31:0] C2   = 32'h1b873593;
    localparam logic [31:0] HADD = 32'he6546b64;
    localparam logic [31:0] F1   = 32'h85ebca6b;
    localparam logic [31:0] F2   = 32'hc2b2ae35;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TLOAD,
        OP_KMUL1,
        OP_KMUL2,
        OP_HMIX,
        OP_TXOR,
        OP_AV1,
        OP_AV2,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   in_ready;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic block_full;
        logic tail_any;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/mm3bsh_dp.sv
// Datapath: byte packing, shared multiplier, hash/length state and output register.
`timescale 1ns / 1ps
`include "murmur3_32_byte_stream_hash_macros.svh"
module mm3bsh_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  logic                   in_valid,
    input  logic [7:0]             data_byte,
    input  logic                   has_byte,
    input  logic                   last_byte,
    input  mm3bsh_pkg::dp_cmd_t    cmd,
    output mm3bsh_pkg::dp_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            digest
);
    import mm3bsh_pkg::*;

    logic [31:0] seed_reg, seed_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] work_reg, work_next;
    logic [23:0] part_reg, part_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic        in_msg_reg, in_msg_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic        accept;
    logic        out_free;
    logic [31:0] base_hash, base_len, fin_x, mix_t;
    logic [23:0] base_part;
    logic [1:0]  base_cnt;
    logic [31:0] mul_a, mul_b, mul_p;

    assign accept   = in_valid && cmd.in_ready && (has_byte || last_byte);
    assign out_free = !out_valid_reg || out_ready;

    assign status.block_full = in_msg_reg && (cnt_reg == 2'd3);
    assign status.tail_any   = (cnt_reg != 2'd0);
    assign status.out_free   = out_free;

    assign fin_x = hash_reg ^ len_reg;
    assign mix_t = {hash_reg[18:0] ^ work_reg[18:0], hash_reg[31:19] ^ work_reg[31:19]};

    always_comb
    begin
        mul_a = work_reg;
        mul_b = C1;
        case (cmd.op)
            OP_KMUL1:
            begin
                mul_a = work_reg;
                mul_b = C1;
            end
            OP_KMUL2:
            begin
                mul_a = {work_reg[16:0], work_reg[31:17]};
                mul_b = C2;
            end
            OP_AV1:
            begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = F1;
            end
            OP_AV2:
            begin
                mul_a = work_reg ^ (work_reg >> 13);
                mul_b = F2;
            end
            default:
            begin
                mul_a = work_reg;
                mul_b = C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        base_hash = in_msg_reg ? hash_reg : seed_reg;
        base_part = in_msg_reg ? part_reg : 24'd0;
        base_cnt  = in_msg_reg ? cnt_reg  : 2'd0;
        base_len  = in_msg_reg ? len_reg  : 32'd0;

        seed_next      = cfg_we ? cfg_wdata : seed_reg;
        hash_next      = hash_reg;
        work_next      = work_reg;
        part_next      = part_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        in_msg_next    = in_msg_reg;
        out_hash_next  = out_hash_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (accept)
        begin
            hash_next   = base_hash;
            part_next   = base_part;
            cnt_next    = base_cnt;
            len_next    = base_len + {31'd0, has_byte};
            in_msg_next = !last_byte;
            if (has_byte)
            begin
                cnt_next = base_cnt + 2'd1;
                case (base_cnt)
                    2'd0: part_next = {base_part[23:8], data_byte};
                    2'd1: part_next = {base_part[23:16], data_byte, base_part[7:0]};
                    2'd2: part_next = {data_byte, base_part[15:0]};
                    default:
                    begin
                        work_next = {data_byte, base_part};
                        part_next = 24'd0;
                    end
                endcase
            end
        end

        case (cmd.op)
            OP_TLOAD: work_next = {8'd0, part_reg};
            OP_KMUL1, OP_KMUL2, OP_AV1, OP_AV2: work_next = mul_p;
            OP_HMIX:  hash_next = {mix_t[29:0], 2'b00} + mix_t + HADD;
            OP_TXOR:  hash_next = hash_reg ^ work_reg;
            OP_OUT:
            begin
                if (out_free)
                begin
                    out_hash_next  = work_reg ^ (work_reg >> 16);
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            cnt_reg       <= 2'd0;
            len_reg       <= 32'd0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        work_reg     <= work_next;
        part_reg     <= part_next;
        out_hash_reg <= out_hash_next;
    end

    assign out_valid = out_valid_reg;
    assign digest    = out_hash_reg;

    `MM3_ASSERT_IMPL(a_mix_after_full_block, clk, rst_n, cmd.op == OP_HMIX, cnt_reg == 2'd0)
    `MM3_ASSERT_NEXT(a_out_loaded, clk, rst_n, cmd.op == OP_OUT && out_free, out_valid_reg)

endmodule

// File: design/mm3bsh_ctrl.sv
// Controller: sequences block mix and finalization on the datapath.
`timescale 1ns / 1ps
`include "murmur3_32_byte_stream_hash_macros.svh"
module mm3bsh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   has_byte,
    input  logic                   last_byte,
    input  mm3bsh_pkg::dp_status_t status,
    output mm3bsh_pkg::dp_cmd_t    cmd
);
    import mm3bsh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BK1,
        S_BK2,
        S_BMIX,
        S_FIN,
        S_TK1,
        S_TK2,
        S_TXOR,
        S_AV1,
        S_AV2,
        S_OUT
    } state_t;

    state_t  state_reg, state_next;
    logic    last_reg, last_next;
    dp_cmd_t cmd_reg, cmd_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = last_byte;
                    if (has_byte && status.block_full)
                        state_next = S_BK1;
                    else if (last_byte)
                        state_next = S_FIN;
                end
            end
            S_BK1:  state_next = S_BK2;
            S_BK2:  state_next = S_BMIX;
            S_BMIX: state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN:  state_next = status.tail_any ? S_TK1 : S_AV1;
            S_TK1:  state_next = S_TK2;
            S_TK2:  state_next = S_TXOR;
            S_TXOR: state_next = S_AV1;
            S_AV1:  state_next = S_AV2;
            S_AV2:  state_next = S_OUT;
            S_OUT:  state_next = status.out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase

        cmd_next.in_ready = (state_next == S_IDLE);
        case (state_next)
            S_BK1, S_TK1: cmd_next.op = OP_KMUL1;
            S_BK2, S_TK2: cmd_next.op = OP_KMUL2;
            S_BMIX:       cmd_next.op = OP_HMIX;
            S_FIN:        cmd_next.op = OP_TLOAD;
            S_TXOR:       cmd_next.op = OP_TXOR;
            S_AV1:        cmd_next.op = OP_AV1;
            S_AV2:        cmd_next.op = OP_AV2;
            S_OUT:        cmd_next.op = OP_OUT;
            default:      cmd_next.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            last_reg         <= 1'b0;
            cmd_reg.in_ready <= 1'b1;
            cmd_reg.op       <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

    `MM3_ASSERT_IMPL(a_ready_only_idle, clk, rst_n, cmd_reg.in_ready, state_reg == S_IDLE)
    `MM3_ASSERT_NEXT(a_last_stalls, clk, rst_n, in_valid && cmd_reg.in_ready && last_byte, !cmd_reg.in_ready)

endmodule

// File: design/murmur3_32_byte_stream_hash.sv
// Top level: MurmurHash3 x86_32 over a byte-per-word stream with a writable seed.
//
// One message byte enters per word, packed little-endian into 32-bit blocks.
// A word that does not complete a block is accepted with no stall. The word
// that completes a block holds the input through the states BK1, BK2 and BMIX
// while the single shared 32x32 multiplier runs the key mix (two multiplies)
// and the hash update. A word with last_byte set adds finalization: a tail
// load, plus the tail key mix and XOR if a 1-3 byte tail remains, plus two
// avalanche multiplies and an output load; the load waits for as long as a
// previous result still sits unaccepted in the output register. After the
// load input is taken again while the result waits in the output register.
// The seed is sampled when the first word of a message is accepted.
`timescale 1ns / 1ps
module murmur3_32_byte_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest
);
    import mm3bsh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mm3bsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .status    (status),
        .cmd       (cmd)
    );

    mm3bsh_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last_byte  (last_byte),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest     (digest)
    );

    assign in_ready = cmd.in_ready;

endmodule

// File: dv/tb_murmur3_32_byte_stream_hash.sv
// Testbench for murmur3_32_byte_stream_hash: byte stream hashing checked against a predictor.
`timescale 1ns / 1ps
module tb_murmur3_32_byte_stream_hash;
    import mm3bsh_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES  = 800;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {
        ACT_WORD,
        ACT_SEED,
        ACT_DRAIN
    } plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        logic [7:0]  byte_val;
        logic        has;
        logic        last;
        logic [31:0] seed_val;
        int          gap;
    } plan_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest;

    plan_entry_t word_plan_q[$];
    logic [31:0] pending_hash_q[$];

    // predictor state
    logic [31:0] seed_shadow = '0;
    logic [31:0] run_hash = '0;
    logic [23:0] tail_bits = '0;
    logic [1:0]  tail_cnt = '0;
    logic [31:0] msg_len = '0;
    logic        msg_open = 1'b0;

    int err_count = 0;
    int hash_seen = 0;
    int gap_left = 0;
    int settle_left = SETTLE_CYCLES;
    int stall_left = 0;
    int hold_left = 0;

    murmur3_32_byte_stream_hash DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest     (digest)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_block(logic [31:0] k);
        logic [31:0] t;
        t = k * C1;
        t = rotl32(t, 15);
        t = t * C2;
        return t;
    endfunction

    function automatic logic [31:0] avalanche32(logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * F1;
        t = t ^ (t >> 13);
        t = t * F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    task automatic absorb_word(logic [7:0] b, logic h_in, logic l_in);
        logic [31:0] h;
        if (!h_in && !l_in)
            return;
        if (!msg_open)
        begin
            run_hash  = seed_shadow;
            tail_bits = '0;
            tail_cnt  = '0;
            msg_len   = '0;
            msg_open  = 1'b1;
        end
        if (h_in)
        begin
            msg_len = msg_len + 32'd1;
            if (tail_cnt == 2'd3)
            begin
                run_hash  = run_hash ^ scramble_block({b, tail_bits});
                run_hash  = rotl32(run_hash, 13);
                run_hash  = run_hash * 32'd5 + HADD;
                tail_bits = '0;
                tail_cnt  = '0;
            end
            else
            begin
                tail_bits[8 * tail_cnt +: 8] = b;
                tail_cnt = tail_cnt + 2'd1;
            end
        end
        if (l_in)
        begin
            h = run_hash;
            if (tail_cnt != 2'd0)
                h = h ^ scramble_block({8'h00, tail_bits});
            h = h ^ msg_len;
            pending_hash_q.push_back(avalanche32(h));
            msg_open  = 1'b0;
            tail_bits = '0;
            tail_cnt  = '0;
            msg_len   = '0;
            run_hash  = seed_shadow;
        end
    endtask

    task automatic flag_error(string what);
        err_count++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function automatic void add_word(logic [7:0] b, logic h, logic l, bit quiet);
        plan_entry_t e;
        e.kind     = ACT_WORD;
        e.byte_val = b;
        e.has      = h;
        e.last     = l;
        e.seed_val = '0;
        e.gap      = quiet ? 0 : $urandom_range(0, 19);
        word_plan_q.push_back(e);
    endfunction

    function automatic void add_ctl(plan_kind_t k, logic [31:0] v);
        plan_entry_t e;
        e.kind     = k;
        e.byte_val = '0;
        e.has      = 1'b0;
        e.last     = 1'b0;
        e.seed_val = v;
        e.gap      = 0;
        word_plan_q.push_back(e);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drv_proc
        plan_entry_t nxt;
        logic nv;
        logic cw;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_we   <= 1'b0;
        end
        else
        begin
            nv = in_valid;
            cw = 1'b0;
            if (in_valid && in_ready)
            begin
                absorb_word(data_byte, has_byte, last_byte);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (word_plan_q.size() != 0)
                begin
                    nxt = word_plan_q[0];
                    if (nxt.kind == ACT_WORD)
                    begin
                        data_byte <= nxt.byte_val;
                        has_byte  <= nxt.has;
                        last_byte <= nxt.last;
                        nv = 1'b1;
                        gap_left = nxt.gap;
                        void'(word_plan_q.pop_front());
                    end
                    else if (pending_hash_q.size() != 0)
                        settle_left = SETTLE_CYCLES;
                    else if (settle_left > 0)
                        settle_left--;
                    else
                    begin
                        if (nxt.kind == ACT_SEED)
                        begin
                            cw = 1'b1;
                            cfg_wdata <= nxt.seed_val;
                            seed_shadow = nxt.seed_val;
                        end
                        settle_left = SETTLE_CYCLES;
                        void'(word_plan_q.pop_front());
                    end
                end
            end
            in_valid <= nv;
            cfg_we   <= cw;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : mon_proc
        logic [31:0] want;
        logic nr;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_hash_q.size() == 0)
                    flag_error($sformatf("unexpected hash %08h", digest));
                else
                begin
                    want = pending_hash_q.pop_front();
                    if (digest !== want)
                        flag_error($sformatf("digest %08h, want %08h", digest, want));
                end
                hash_seen++;
                if (hash_seen == 15 || hash_seen == 90)
                    hold_left = HOLD_CYCLES;
                stall_left = ((hash_seen / 25) % 3 == 1) ? 0 : $urandom_range(0, 19);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nr = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nr = 1'b0;
            end
            else
                nr = 1'b1;
            out_ready <= nr;
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int word_total;
        int len;
        int sel;
        bit quiet;
        bit split_end;

        // directed: empty message, tails of 1 to 3 bytes, full blocks, idle word,
        // separate terminator, seed extremes
        add_ctl(ACT_SEED, 32'h0000_0000);
        add_word(8'h5a, 1'b0, 1'b1, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 1'b0);
        add_word(8'hff, 1'b1, 1'b1, 1'b0);
        add_word(8'h01, 1'b1, 1'b0, 1'b0);
        add_word(8'h02, 1'b1, 1'b1, 1'b0);
        add_word(8'ha5, 1'b1, 1'b0, 1'b1);
        add_word(8'h5a, 1'b1, 1'b0, 1'b1);
        add_word(8'hff, 1'b1, 1'b1, 1'b1);
        add_word(8'h80, 1'b1, 1'b0, 1'b0);
        add_word(8'h7f, 1'b1, 1'b0, 1'b0);
        add_word(8'h00, 1'b1, 1'b0, 1'b0);
        add_word(8'hff, 1'b1, 1'b1, 1'b0);
        add_word(8'h11, 1'b1, 1'b0, 1'b0);
        add_word(8'hff, 1'b0, 1'b0, 1'b0);
        add_word(8'h22, 1'b1, 1'b0, 1'b0);
        add_word(8'h33, 1'b1, 1'b0, 1'b0);
        add_word(8'h44, 1'b1, 1'b0, 1'b0);
        add_word(8'h55, 1'b1, 1'b1, 1'b0);
        add_word(8'hc3, 1'b1, 1'b0, 1'b1);
        add_word(8'h3c, 1'b1, 1'b0, 1'b1);
        add_word(8'he7, 1'b1, 1'b0, 1'b1);
        add_word(8'h00, 1'b0, 1'b1, 1'b1);
        add_ctl(ACT_SEED, 32'hffff_ffff);
        add_word(8'h00, 1'b0, 1'b1, 1'b0);
        repeat (3)
            add_word(8'hff, 1'b1, 1'b0, 1'b0);
        add_word(8'hff, 1'b1, 1'b1, 1'b0);
        add_ctl(ACT_DRAIN, '0);

        word_total = 0;
        while (word_total < RANDOM_BYTES)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                add_ctl(ACT_SEED, ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff);
            else if (sel <= 2)
                add_ctl(ACT_SEED, $urandom);
            else if (sel == 3)
                add_ctl(ACT_DRAIN, '0);
            repeat ($urandom_range(1, 6))
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                split_end = (len == 0) || ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, quiet);
                    add_word(8'($urandom_range(0, 255)), 1'b1, !split_end && i == len - 1,
                             quiet);
                    word_total++;
                end
                if (split_end)
                begin
                    add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, quiet);
                    word_total++;
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (word_plan_q.size() != 0 || in_valid || pending_hash_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/mm3bsh_pkg.sv
design/mm3bsh_dp.sv
design/mm3bsh_ctrl.sv
design/murmur3_32_byte_stream_hash.sv
dv/tb_murmur3_32_byte_stream_hash.sv
